// ===== hw/rtl/sfbd_pkg.sv =====
// Shared types and codes for the shadow framebuffer diff/update block.
package sfbd_pkg;

    // One request transaction
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] x_pos;
        logic [6:0] y_pos;
        logic [7:0] span_width;
        logic [7:0] span_height;
    } req_t;

    // One redraw result transaction
    typedef struct packed {
        logic [7:0] pix_x;
        logic [6:0] pix_y;
        logic       level;
        logic       changed;
        logic       last;
    } res_t;

    localparam logic [1:0] REQ_SET     = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_REGION  = 2'd2;
    localparam logic [1:0] REQ_REFRESH = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic init_wr;
        logic load;
        logic row_rd;
        logic draw_wr;
        logic row_next;
        logic col_step;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic init_last;
        logic is_refresh;
        logic more_rows;
        logic span_done;
        logic can_push;
    } stat_t;

endpackage

// ===== hw/rtl/sfbd_datapath.sv =====
// Datapath: plane memories, row buffers, span walker and result register.
module sfbd_datapath #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 128,
    parameter int MAX_SPAN     = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sfbd_pkg::cmd_t cmd,
    output sfbd_pkg::stat_t stat,
    input  sfbd_pkg::req_t req,
    input  logic           cfg_valid,
    input  logic           cfg_data,
    input  logic           out_stall,
    output logic           out_valid,
    output sfbd_pkg::res_t out_data
);

    localparam int XW  = $clog2(PANEL_WIDTH);
    localparam int XLW = $clog2(PANEL_WIDTH + 1);
    localparam int XCW = (XLW > 8) ? XLW : 8;
    localparam int YW  = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int YLW = YW + 1;
    localparam int YCW = (YLW > 7) ? YLW : 7;
    localparam logic [7:0] SPAN_CAP = 8'(MAX_SPAN);

    // Plane memories, one physical row per entry
    logic [PANEL_WIDTH-1:0] draw_mem  [PANEL_HEIGHT];
    logic [PANEL_WIDTH-1:0] shown_mem [PANEL_HEIGHT];

    logic                   rot_reg;
    logic [1:0]             kind_reg;
    logic [XW-1:0]          x_reg;
    logic [YW-1:0]          ly_reg;
    logic [7:0]             len_reg;
    logic [7:0]             rows_reg;
    logic [XLW-1:0]         lc_reg;
    logic [7:0]             rem_reg;
    logic [YW-1:0]          init_cnt_reg;
    logic [PANEL_WIDTH-1:0] draw_row_reg;
    logic [PANEL_WIDTH-1:0] shown_row_reg;
    logic [PANEL_WIDTH-1:0] upd_reg;
    logic                   pend_valid_reg;
    logic [XW-1:0]          pend_x_reg;
    logic                   pend_level_reg;
    logic                   out_valid_reg;
    sfbd_pkg::res_t         out_data_reg;

    logic [XW-1:0]          x_sat;
    logic [YW-1:0]          y_sat;
    logic [7:0]             len_next;
    logic [YW-1:0]          py;
    logic [XW-1:0]          px;
    logic [PANEL_WIDTH-1:0] mask;
    logic [PANEL_WIDTH-1:0] draw_new;
    logic [PANEL_WIDTH-1:0] shown_new;
    logic                   pix_draw;
    logic                   pix_shown;
    logic                   diff;
    logic                   push;
    sfbd_pkg::res_t         push_data;
    logic                   can_push;

    // Saturate request coordinates to the panel
    assign x_sat = (XCW'(req.x_pos) >= XCW'(PANEL_WIDTH)) ? XW'(PANEL_WIDTH - 1)
                                                          : XW'(req.x_pos);
    assign y_sat = (YCW'(req.y_pos) >= YCW'(PANEL_HEIGHT)) ? YW'(PANEL_HEIGHT - 1)
                                                           : YW'(req.y_pos);

    always_comb
    begin
        case (req.req_type)
            sfbd_pkg::REQ_SET,
            sfbd_pkg::REQ_CLEAR:   len_next = 8'd1;
            sfbd_pkg::REQ_REGION:  len_next = (req.span_height == 8'd0) ? 8'd0
                                                                        : req.span_width;
            sfbd_pkg::REQ_REFRESH: len_next = (req.span_width > SPAN_CAP) ? SPAN_CAP
                                                                         : req.span_width;
            default:               len_next = 8'd0;
        endcase
    end

    assign py = rot_reg ? YW'(PANEL_HEIGHT - 1) - ly_reg : ly_reg;
    assign px = rot_reg ? XW'(PANEL_WIDTH - 1) - lc_reg[XW-1:0] : lc_reg[XW-1:0];

    // Column mask of logical span [x, x+len) in physical order
    always_comb
    begin
        logic [XW-1:0] lp;
        for (int p = 0; p < PANEL_WIDTH; p++)
        begin
            lp = rot_reg ? XW'(PANEL_WIDTH - 1 - p) : XW'(p);
            mask[p] = (lp >= x_reg) && (XCW'(lp - x_reg) < XCW'(len_reg));
        end
    end

    assign draw_new  = (kind_reg == sfbd_pkg::REQ_SET) ? (draw_row_reg | mask)
                                                       : (draw_row_reg & ~mask);
    assign shown_new = shown_row_reg ^ upd_reg;

    assign pix_draw  = draw_row_reg[px];
    assign pix_shown = shown_row_reg[px] ^ upd_reg[px];
    assign diff      = pix_draw != pix_shown;

    assign can_push = !out_valid_reg || !out_stall;
    assign push     = (cmd.col_step && diff && pend_valid_reg) || cmd.finish;

    always_comb
    begin
        push_data.pix_x   = 8'(pend_x_reg);
        push_data.pix_y   = 7'(py);
        push_data.level   = pend_level_reg;
        push_data.changed = 1'b1;
        push_data.last    = cmd.finish;
        if (cmd.finish && !pend_valid_reg)
        begin
            push_data = '0;
            push_data.last = 1'b1;
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
            draw_mem[init_cnt_reg] <= '0;
        else if (cmd.draw_wr)
            draw_mem[py] <= draw_new;
        if (cmd.row_rd)
            draw_row_reg <= draw_mem[py];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
            shown_mem[init_cnt_reg] <= '0;
        else if (cmd.finish)
            shown_mem[py] <= shown_new;
        if (cmd.row_rd)
            shown_row_reg <= shown_mem[py];
    end

    // Request and walker payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.req_type;
            x_reg    <= x_sat;
            ly_reg   <= y_sat;
            len_reg  <= len_next;
            // only a region clear spans several rows
            rows_reg <= (req.req_type == sfbd_pkg::REQ_REGION) ? req.span_height : 8'd1;
            lc_reg   <= XLW'(x_sat);
            rem_reg  <= len_next;
        end
        if (cmd.row_next)
        begin
            ly_reg   <= ly_reg + 1'b1;
            rows_reg <= rows_reg - 8'd1;
        end
        if (cmd.row_rd)
            upd_reg <= '0;
        if (cmd.col_step)
        begin
            lc_reg  <= lc_reg + 1'b1;
            rem_reg <= rem_reg - 8'd1;
            if (diff)
            begin
                upd_reg[px]    <= 1'b1;
                pend_x_reg     <= px;
                pend_level_reg <= pix_draw;
            end
        end
        if (push)
            out_data_reg <= push_data;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg        <= 1'b0;
            init_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                rot_reg <= cfg_data;
            if (cmd.init_wr)
                init_cnt_reg <= init_cnt_reg + 1'b1;
            if (cmd.finish)
                pend_valid_reg <= 1'b0;
            else if (cmd.col_step && diff)
                pend_valid_reg <= 1'b1;
            if (push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.init_last  = init_cnt_reg == YW'(PANEL_HEIGHT - 1);
    assign stat.is_refresh = kind_reg == sfbd_pkg::REQ_REFRESH;
    assign stat.more_rows  = (rows_reg > 8'd1)
                             && ((YLW'(ly_reg) + 1'b1) < YLW'(PANEL_HEIGHT));
    assign stat.span_done  = (rem_reg == 8'd0) || (lc_reg >= XLW'(PANEL_WIDTH));
    assign stat.can_push   = can_push;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/sfbd_ctrl.sv =====
// Controller: sequences clearing pass, pixel/region writes and refresh walks.
module sfbd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sfbd_pkg::stat_t stat,
    output sfbd_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_WALK = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = stat.is_refresh ? ST_WALK : ST_MOD;
            end
            ST_MOD:
            begin
                cmd.draw_wr = 1'b1;
                if (stat.more_rows)
                begin
                    cmd.row_next = 1'b1;
                    state_next   = ST_RD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (stat.span_done)
                    state_next = ST_FIN;
                else if (stat.can_push)
                    cmd.col_step = 1'b1;
            end
            ST_FIN:
            begin
                if (stat.can_push)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    assign in_stall = state_reg != ST_IDLE;

endmodule

// ===== hw/rtl/shadow_framebuffer_diff_update.sv =====
// Top level: 1-bit framebuffer with drawing plane, shown mirror and refresh diff.
//
// Request channel (in_valid/in_stall/in_data): set pixel, clear pixel, clear
// region, refresh row span. One request is handled at a time.
// Result channel (out_valid/out_stall/out_data): refresh only; one result per
// pixel that differs between the planes, the final one flagged last, or a single
// empty last result when the span is clean.
// Config channel (cfg_valid/cfg_ready/cfg_data): view rotation bit, always ready.
// Sequence: set/clear pixel reads then writes one physical row; clear region
// reads then writes each physical row in turn; refresh reads the row, walks
// the span one pixel per cycle while no result waits behind out_stall, checks
// for the end of the span and writes the mirror row back.
// Results sit in one output register; a new request can be accepted while the
// last result of a refresh still waits there.
// After reset both planes are cleared one row per cycle, each row in turn,
// with in_stall high; configuration writes are taken meanwhile.
// A stalled receiver only pauses a refresh (span walk and final result); nothing is dropped.
module shadow_framebuffer_diff_update #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 128,
    parameter int MAX_SPAN     = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sfbd_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output sfbd_pkg::res_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    sfbd_pkg::cmd_t  cmd;
    sfbd_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    sfbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfbd_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_SPAN     (MAX_SPAN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== bench/shadow_framebuffer_diff_update_checker.sv =====
// Checker: predicts the redraw results of the shadow framebuffer and compares them.
module shadow_framebuffer_diff_update_checker #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 128,
    parameter int MAX_SPAN     = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  sfbd_pkg::req_t in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  sfbd_pkg::res_t out_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic           cfg_data,
    output int             fail_count,
    output int             expected_left,
    output int             results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // both planes indexed by physical row, then physical column
    bit             draw_px  [PANEL_HEIGHT][PANEL_WIDTH];
    bit             shown_px [PANEL_HEIGHT][PANEL_WIDTH];
    bit             rotated;
    sfbd_pkg::res_t redraw_q [$];
    sfbd_pkg::res_t want;

    function automatic int clamp_to(int v, int lim);
        return (v >= lim) ? lim - 1 : v;
    endfunction

    function automatic int phys_col(int x);
        return rotated ? PANEL_WIDTH - 1 - x : x;
    endfunction

    function automatic int phys_row(int y);
        return rotated ? PANEL_HEIGHT - 1 - y : y;
    endfunction

    // Applies one request to the planes and queues the redraw commands it causes.
    function automatic void predict_request(sfbd_pkg::req_t r);
        int             x, y, w, h, px, py;
        sfbd_pkg::res_t pending;
        bit             have_pending;
        x = clamp_to(int'(r.x_pos), PANEL_WIDTH);
        y = clamp_to(int'(r.y_pos), PANEL_HEIGHT);
        w = int'(r.span_width);
        h = int'(r.span_height);
        pending = '0;
        have_pending = 1'b0;
        case (r.req_type)
            sfbd_pkg::REQ_SET, sfbd_pkg::REQ_CLEAR:
                draw_px[phys_row(y)][phys_col(x)] = (r.req_type == sfbd_pkg::REQ_SET);
            sfbd_pkg::REQ_REGION:
                for (int j = 0; j < h && y + j < PANEL_HEIGHT; j++)
                    for (int i = 0; i < w && x + i < PANEL_WIDTH; i++)
                        draw_px[phys_row(y + j)][phys_col(x + i)] = 1'b0;
            default:
            begin
                if (w > MAX_SPAN)
                    w = MAX_SPAN;
                py = phys_row(y);
                for (int i = 0; i < w && x + i < PANEL_WIDTH; i++)
                begin
                    px = phys_col(x + i);
                    if (draw_px[py][px] != shown_px[py][px])
                    begin
                        shown_px[py][px] = draw_px[py][px];
                        // a newer change means the held one is not last
                        if (have_pending)
                            redraw_q.push_back(pending);
                        pending.pix_x   = 8'(px);
                        pending.pix_y   = 7'(py);
                        pending.level   = draw_px[py][px];
                        pending.changed = 1'b1;
                        pending.last    = 1'b0;
                        have_pending    = 1'b1;
                    end
                end
                // clean span: pending is still all zero, i.e. the empty completion
                pending.last = 1'b1;
                redraw_q.push_back(pending);
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int row = 0; row < PANEL_HEIGHT; row++)
                for (int col = 0; col < PANEL_WIDTH; col++)
                begin
                    draw_px[row][col]  = 1'b0;
                    shown_px[row][col] = 1'b0;
                end
            rotated = 1'b0;
            redraw_q.delete();
            fail_count = 0;
            results_checked = 0;
            expected_left <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rotated = cfg_data;
            if (in_valid && !in_stall)
                predict_request(in_data);
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (redraw_q.size() == 0)
                begin
                    $error("redraw transaction with nothing expected: x %0d y %0d level %0d",
                           out_data.pix_x, out_data.pix_y, out_data.level);
                    fail_count++;
                end
                else
                begin
                    want = redraw_q.pop_front();
                    check_field("pix_x", want.pix_x, out_data.pix_x);
                    check_field("pix_y", want.pix_y, out_data.pix_y);
                    check_field("level", want.level, out_data.level);
                    check_field("changed", want.changed, out_data.changed);
                    check_field("last", want.last, out_data.last);
                end
            end
            expected_left <= redraw_q.size();
        end
    end

endmodule

// ===== bench/shadow_framebuffer_diff_update_test.sv =====
// Testbench top: clock, reset, request and config traffic, and the verdict.
module shadow_framebuffer_diff_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PANEL_WIDTH   = 240;
    localparam int PANEL_HEIGHT  = 128;
    localparam int MAX_SPAN      = 64;
    // full-height region clear is the slowest request, one row read and one row write per row
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_NS      = 25_000_000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    sfbd_pkg::req_t in_data;
    logic           out_valid;
    logic           out_stall;
    sfbd_pkg::res_t out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic           cfg_data;

    int fail_count;
    int expected_left;
    int results_checked;
    int kind_count [4] = '{default: 0};
    int hold_asks = 0;
    int burst_left = 0;

    shadow_framebuffer_diff_update #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_SPAN     (MAX_SPAN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    shadow_framebuffer_diff_update_checker #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_SPAN     (MAX_SPAN)
    ) redraw_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: alternating ready and stall stretches, plus long hold-offs on request.
    initial
    begin : receiver
        int  hold_left;
        int  run_left;
        int  holds_taken;
        int  roll;
        bit  holding_back;
        hold_left = 0;
        run_left = 0;
        holds_taken = 0;
        holding_back = 1'b1;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_taken != hold_asks)
            begin
                holds_taken = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    holding_back = !holding_back;
                    roll = $urandom_range(0, 99);
                    if (holding_back)
                        run_left = (roll < 70) ? $urandom_range(1, 2) :
                                   (roll < 95) ? $urandom_range(3, 6) : $urandom_range(10, 20);
                    else
                        run_left = (roll < 50) ? $urandom_range(1, 4) :
                                   (roll < 85) ? $urandom_range(5, 15) : $urandom_range(30, 80);
                end
                run_left--;
                out_stall <= holding_back;
            end
        end
    end

    function automatic int sender_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            burst_left = $urandom_range(15, 30);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic sfbd_pkg::req_t make_req(logic [1:0] kind, int x, int y, int w, int h);
        sfbd_pkg::req_t r;
        r.req_type    = kind;
        r.x_pos       = 8'(x);
        r.y_pos       = 7'(y);
        r.span_width  = 8'(w);
        r.span_height = 8'(h);
        return r;
    endfunction

    // Mostly drawing and refreshing around one focus row; some requests land anywhere.
    function automatic sfbd_pkg::req_t random_req(int fx, int fy);
        sfbd_pkg::req_t r;
        int             roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r.req_type = sfbd_pkg::REQ_SET;
        else if (roll < 60)
            r.req_type = sfbd_pkg::REQ_CLEAR;
        else if (roll < 68)
            r.req_type = sfbd_pkg::REQ_REGION;
        else
            r.req_type = sfbd_pkg::REQ_REFRESH;
        r.span_height = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
        begin
            r.x_pos      = 8'($urandom_range(0, 255));
            r.y_pos      = 7'($urandom_range(0, 127));
            r.span_width = 8'($urandom_range(0, 255));
        end
        else
        begin
            r.x_pos      = 8'(fx + $urandom_range(0, 63));
            r.y_pos      = 7'(fy);
            r.span_width = 8'($urandom_range(1, MAX_SPAN));
            if (r.req_type == sfbd_pkg::REQ_REFRESH)
                r.x_pos = 8'(fx);
            if (r.req_type == sfbd_pkg::REQ_REGION)
                r.span_height = 8'($urandom_range(1, 3));
        end
        return r;
    endfunction

    task automatic send_req(input sfbd_pkg::req_t r);
        int gap;
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        kind_count[r.req_type]++;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait for every outstanding result, then for any request that returns none.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_view(input logic rot);
        cfg_valid <= 1'b1;
        cfg_data  <= rot;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int fx;
        int fy;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // straight view: edges, saturation, clipping, empty and wide spans
        write_view(1'b0);
        send_req(make_req(sfbd_pkg::REQ_SET, 0, 0, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_SET, 255, 127, 255, 255));
        send_req(make_req(sfbd_pkg::REQ_SET, 240, 5, 0, 0));
        send_req(make_req(sfbd_pkg::REQ_SET, 63, 0, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_SET, 64, 0, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_CLEAR, 63, 0, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, 0, 255, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 200, 127, MAX_SPAN, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 250, 5, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, 0, 0, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, 0, MAX_SPAN, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 64, 0, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_REGION, 0, 0, 0, 5));
        send_req(make_req(sfbd_pkg::REQ_REGION, 0, 0, 5, 0));
        send_req(make_req(sfbd_pkg::REQ_REGION, 230, 120, 255, 255));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 176, 127, MAX_SPAN, 1));
        send_req(make_req(sfbd_pkg::REQ_SET, 10, 40, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_REGION, 0, 0, PANEL_WIDTH, PANEL_HEIGHT));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, 0, MAX_SPAN, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 64, 0, MAX_SPAN, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 255, 5, 200, 1));
        send_req(make_req(sfbd_pkg::REQ_CLEAR, 255, 127, 1, 1));
        drain();

        // rotated view: opposite corners swap
        write_view(1'b1);
        send_req(make_req(sfbd_pkg::REQ_SET, 0, 0, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_SET, 239, 127, 1, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, 0, MAX_SPAN, 1));
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 239, 127, MAX_SPAN, 1));
        drain();

        // set pixels in one row, refresh it while the receiver holds off, then alternate sets and refreshes
        fy = $urandom_range(0, PANEL_HEIGHT - 1);
        repeat (24)
            send_req(make_req(sfbd_pkg::REQ_SET, $urandom_range(0, MAX_SPAN - 1), fy, 1, 1));
        hold_asks++;
        send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, fy, MAX_SPAN, 1));
        repeat (3)
        begin
            send_req(make_req(sfbd_pkg::REQ_SET, $urandom_range(0, MAX_SPAN - 1), fy, 1, 1));
            send_req(make_req(sfbd_pkg::REQ_REFRESH, 0, fy, MAX_SPAN, 1));
        end
        drain();

        for (int seg = 0; seg < 4; seg++)
        begin
            write_view((seg % 2) == 0);
            for (int n = 0; n < 75; n++)
            begin
                if (n % 25 == 0)
                begin
                    fx = $urandom_range(0, 192);
                    fy = $urandom_range(0, PANEL_HEIGHT - 1);
                end
                send_req(random_req(fx, fy));
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            drain();
        end

        $display("Requests: %0d set, %0d clear, %0d region clear, %0d refresh, both rotations.",
                 kind_count[sfbd_pkg::REQ_SET], kind_count[sfbd_pkg::REQ_CLEAR],
                 kind_count[sfbd_pkg::REQ_REGION], kind_count[sfbd_pkg::REQ_REFRESH]);
        $display("Redraw transactions checked: %0d.", results_checked);
        if (fail_count == 0 && expected_left == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sfbd_pkg.sv
hw/rtl/sfbd_datapath.sv
hw/rtl/sfbd_ctrl.sv
hw/rtl/shadow_framebuffer_diff_update.sv
bench/shadow_framebuffer_diff_update_checker.sv
bench/shadow_framebuffer_diff_update_test.sv
